// ----- rtl/tprd_pkg.sv -----
package tprd_pkg;

	localparam int unsigned TorqueWidth   = 16;
	localparam int unsigned DutyWidth     = 7;
	localparam int unsigned DwellWidth    = 8;
	localparam int unsigned CfgIndexWidth = 1;
	localparam int unsigned ProductWidth  = TorqueWidth + DutyWidth;
	localparam int unsigned OutDataWidth  = 32;

	localparam logic [CfgIndexWidth-1:0] CfgTargetTorque = 1'b0;
	localparam logic [CfgIndexWidth-1:0] CfgReportDelay  = 1'b1;

	localparam logic [TorqueWidth-1:0] TargetReset = 16'd0;
	localparam logic [TorqueWidth-1:0] DelayReset  = 16'd500;
	localparam logic [DutyWidth-1:0]   PercentFull = 7'd100;
	localparam logic [DwellWidth-1:0]  DwellMax    = 8'd255;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic                   valid;
		logic [TorqueWidth-1:0] value;
	} report_t;

endpackage

// ----- rtl/tprd_div.sv -----
module tprd_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [tprd_pkg::ProductWidth-1:0]   dividend,
	input  logic [tprd_pkg::TorqueWidth-1:0]    divisor,
	output tprd_pkg::div_stat_t                 stat,
	output logic [tprd_pkg::DutyWidth-1:0]      quotient
);
	import tprd_pkg::*;

	localparam int unsigned CntWidth = $clog2(DutyWidth + 1);

	logic [TorqueWidth-1:0] rem_q;
	logic [TorqueWidth-1:0] div_q;
	logic [DutyWidth-1:0]   num_q;
	logic [DutyWidth-1:0]   quo_q;
	logic [CntWidth-1:0]    cnt_q;
	logic [TorqueWidth:0]   trial;
	logic                   fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[DutyWidth-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntWidth'(DutyWidth);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[ProductWidth-1:DutyWidth];
			num_q <= dividend[DutyWidth-1:0];
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? TorqueWidth'(trial - {1'b0, div_q}) : trial[TorqueWidth-1:0];
			num_q <= {num_q[DutyWidth-2:0], 1'b0};
			quo_q <= {quo_q[DutyWidth-2:0], fits};
		end
	end

	assign stat.busy = cnt_q != '0;
	assign stat.done = cnt_q == CntWidth'(1);
	assign quotient  = quo_q;

endmodule

// ----- rtl/tprd_peak.sv -----
module tprd_peak (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic [tprd_pkg::TorqueWidth-1:0]  sample,
	input  logic                              restart,
	input  logic [tprd_pkg::TorqueWidth-1:0]  target,
	input  logic [tprd_pkg::TorqueWidth-1:0]  delay,
	output tprd_pkg::report_t                 report
);
	import tprd_pkg::*;

	logic [TorqueWidth-1:0] peak_q;
	logic [TorqueWidth-1:0] last_q;
	logic [DwellWidth-1:0]  dwell_q;
	report_t                report_q;

	logic [TorqueWidth-1:0] peak_base;
	logic [TorqueWidth-1:0] peak_new;
	logic [DwellWidth-1:0]  dwell_inc;
	logic [TorqueWidth-1:0] dwell_ms;
	logic                   keep;
	logic                   hit;
	logic                   fire;

	always_comb begin
		peak_base = restart ? '0 : peak_q;
		peak_new  = (sample > peak_base) ? sample : peak_base;
		keep      = peak_new >= target;
		dwell_inc = (dwell_q < DwellMax) ? dwell_q + 1'b1 : dwell_q;
		dwell_ms  = TorqueWidth'(dwell_inc) * TorqueWidth'(PercentFull);
		hit       = (dwell_ms >= delay) && (peak_new > target);
		fire      = hit && (last_q != peak_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q         <= '0;
			last_q         <= '0;
			dwell_q        <= '0;
			report_q.valid <= 1'b0;
			report_q.value <= '0;
		end else if (take) begin
			peak_q         <= peak_new;
			last_q         <= hit ? peak_new : last_q;
			dwell_q        <= (keep && !fire) ? dwell_inc : '0;
			report_q.valid <= fire;
			report_q.value <= fire ? peak_new : '0;
		end
	end

	assign report = report_q;

endmodule

// ----- rtl/torque_peak_report_and_proximity_duty_core.sv -----
// channel  | direction | handshake                 | payload
// s_axis   | in        | s_tvalid / s_tready       | tdata torque_sample, tuser restart_peak
// m_axis   | out       | m_tvalid / m_tready       | tdata duty, flags, report value
// cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A sample goes from acceptance through ST_DIV, where the bit-serial divider forms
// the seven quotient bits one per step, to ST_OUT, where the output register loads.
// No new sample is accepted while one is in ST_DIV or ST_OUT.
// The next sample is accepted the cycle after the output register loads, even
// while that result still waits on m_tready; a stalled output holds the block
// before the output load. cfg_ready is always high. arst_n clears FSM and config state.
module torque_peak_report_and_proximity_duty_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,   // [15:0] torque_sample
	input  logic                                s_tuser,   // [0] restart_peak
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [6:0] duty_percent, [7] duty_changed, [8] torch_on, [9] report_valid,
	// [25:10] report_value, [31:26] zero
	output logic [tprd_pkg::OutDataWidth-1:0]   m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tprd_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [tprd_pkg::TorqueWidth-1:0]    cfg_data
);
	import tprd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [TorqueWidth-1:0]  target_q;
	logic [TorqueWidth-1:0]  delay_q;
	logic                    zero_q;
	logic                    torch_q;
	logic [DutyWidth-1:0]    prev_duty_q;
	logic                    m_tvalid_q;
	logic [OutDataWidth-1:0] m_tdata_q;

	logic                    s_take;
	logic                    load_out;
	logic [TorqueWidth-1:0]  diff;
	logic [ProductWidth-1:0] product;
	logic [TorqueWidth+2:0]  sample_x4;
	logic [TorqueWidth+2:0]  target_x3;
	logic [DutyWidth-1:0]    duty;
	div_stat_t               div_stat;
	logic [DutyWidth-1:0]    quotient;
	report_t                 report;

	assign s_tready  = state_q == ST_IDLE;
	assign s_take    = s_tvalid && s_tready;
	assign load_out  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;

	always_comb begin
		diff      = target_q - s_tdata;
		product   = ProductWidth'(diff) * ProductWidth'(PercentFull);
		sample_x4 = {1'b0, s_tdata, 2'b00};
		target_x3 = {2'b00, target_q, 1'b0} + {3'b000, target_q};
		duty      = zero_q ? '0 : quotient;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TargetReset;
			delay_q  <= DelayReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CfgTargetTorque: target_q <= cfg_data;
				CfgReportDelay:  delay_q  <= cfg_data;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			zero_q  <= (s_tdata > target_q) || (target_q == '0);
			torch_q <= sample_x4 > target_x3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			prev_duty_q <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !load_out) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_take) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						m_tvalid_q  <= 1'b1;
						m_tdata_q   <= {6'b000000, report.value, report.valid, torch_q,
							duty != prev_duty_q, duty};
						prev_duty_q <= duty;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	tprd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_take),
		.dividend (product),
		.divisor  (target_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	tprd_peak u_peak (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (s_take),
		.sample  (s_tdata),
		.restart (s_tuser),
		.target  (target_q),
		.delay   (delay_q),
		.report  (report)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- rtl/tprd_chk.sv -----
module tprd_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [15:0]                         s_tdata,
	input logic                                s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [tprd_pkg::OutDataWidth-1:0]   m_tdata,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [tprd_pkg::CfgIndexWidth-1:0]  cfg_index,
	input logic [tprd_pkg::TorqueWidth-1:0]    cfg_data
);
	import tprd_pkg::*;

	// one sample in flight: no back-to-back input transactions
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a sample is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output transaction changed");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] <= PercentFull)
		else $error("duty above full scale");

	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[9] |-> m_tdata[25:10] == '0 && m_tdata[31:26] == '0)
		else $error("report value set without report");

endmodule

bind torque_peak_report_and_proximity_duty_core tprd_chk u_chk (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import tprd_pkg::*;

	localparam int CycleLimit = 1_000_000;
	localparam int PrintCap   = 40;

	typedef struct packed {
		logic [5:0]             pad;
		logic [TorqueWidth-1:0] report_value;
		logic                   report_valid;
		logic                   torch_on;
		logic                   duty_changed;
		logic [DutyWidth-1:0]   duty_percent;
	} tick_word_t;

	class torque_tick_scoreboard;
		logic [TorqueWidth-1:0] target;
		logic [TorqueWidth-1:0] delay_ms;
		logic [TorqueWidth-1:0] peak;
		logic [TorqueWidth-1:0] last_sent;
		logic [DwellWidth-1:0]  dwell;
		logic [DutyWidth-1:0]   prev_duty;
		tick_word_t             ticks_due[$];
		int                     errors;

		function new();
			target    = TargetReset;
			delay_ms  = DelayReset;
			peak      = '0;
			last_sent = '0;
			dwell     = '0;
			prev_duty = '0;
			errors    = 0;
		endfunction

		function void log_mismatch(string msg);
			if (errors < PrintCap) begin
				$display("%0t mismatch: %s", $realtime, msg);
			end
			errors++;
		endfunction

		function void set_register(logic [CfgIndexWidth-1:0] idx, logic [TorqueWidth-1:0] data);
			if (idx == CfgTargetTorque) begin
				target = data;
			end else if (idx == CfgReportDelay) begin
				delay_ms = data;
			end
		endfunction

		function int waiting();
			return ticks_due.size();
		endfunction

		function void take_sample(logic [TorqueWidth-1:0] sample, logic restart);
			int unsigned t;
			int unsigned s;
			int unsigned duty;
			int unsigned dwell_ms;
			logic        hold;
			tick_word_t  r;
			t = target;
			s = sample;
			r = '0;
			if (s > t || t == 0) begin
				duty = 0;
			end else begin
				duty = (t - s) * 100 / t;
			end
			r.duty_percent = duty[DutyWidth-1:0];
			r.duty_changed = (duty[DutyWidth-1:0] != prev_duty);
			prev_duty      = duty[DutyWidth-1:0];
			r.torch_on     = (s > t * 75 / 100);

			if (restart) begin
				peak = '0;
			end
			if (sample > peak) begin
				peak = sample;
			end
			hold = (peak >= target);
			if (dwell != DwellMax) begin
				dwell++;
			end
			dwell_ms = dwell;
			dwell_ms = dwell_ms * 100;
			if (dwell_ms >= delay_ms && peak > target) begin
				if (last_sent != peak) begin
					r.report_valid = 1'b1;
					r.report_value = peak;
					hold           = 1'b0;
					dwell          = '0;
				end
				last_sent = peak;
			end
			if (!hold) begin
				dwell = '0;
			end
			ticks_due.push_back(r);
		endfunction

		function void check_tick(logic [OutDataWidth-1:0] word);
			tick_word_t got;
			tick_word_t want;
			got = word;
			if (ticks_due.size() == 0) begin
				log_mismatch($sformatf("result %h with no sample pending", word));
				return;
			end
			want = ticks_due.pop_front();
			if (got.duty_percent != want.duty_percent)
				log_mismatch($sformatf("duty_percent %0d, want %0d",
					got.duty_percent, want.duty_percent));
			if (got.duty_changed != want.duty_changed)
				log_mismatch($sformatf("duty_changed %b, want %b",
					got.duty_changed, want.duty_changed));
			if (got.torch_on != want.torch_on)
				log_mismatch($sformatf("torch_on %b, want %b", got.torch_on, want.torch_on));
			if (got.report_valid != want.report_valid)
				log_mismatch($sformatf("report_valid %b, want %b",
					got.report_valid, want.report_valid));
			if (got.report_value != want.report_value)
				log_mismatch($sformatf("report_value %0d, want %0d",
					got.report_value, want.report_value));
			if (got.pad != '0)
				log_mismatch($sformatf("upper bits %b not zero", got.pad));
		endfunction
	endclass

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [TorqueWidth-1:0]   s_tdata   = '0;
	logic                     s_tuser   = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [OutDataWidth-1:0]  m_tdata;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index = CfgTargetTorque;
	logic [TorqueWidth-1:0]   cfg_data  = '0;

	logic        calm = 1'b0;
	int          cycles = 0;
	int          sent = 0;
	int unsigned tgt[9];
	int unsigned dly[9];

	torque_tick_scoreboard sb = new();

	torque_peak_report_and_proximity_duty_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_tick(m_tdata);
		end
	end

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TorqueWidth-1:0] clamp16(int unsigned v);
		if (v > 32'hFFFF)
			return 16'hFFFF;
		return v[TorqueWidth-1:0];
	endfunction

	function automatic logic [TorqueWidth-1:0] near_target(int unsigned t);
		int unsigned span;
		int unsigned v;
		span = t / 8 + 3;
		v = t + $urandom_range(0, span);
		v = (v > span / 3) ? v - span / 3 : 0;
		if ($urandom_range(0, 5) == 0)
			v = t;
		return clamp16(v);
	endfunction

	// stall pattern on the result side
	initial begin
		int stall;
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			stall = calm ? 0 : pause_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	task automatic push_sample(logic [TorqueWidth-1:0] smp, logic rst);
		int gap;
		gap = calm ? 0 : pause_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= rst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.take_sample(smp, rst);
		sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.waiting() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_limits(int unsigned t, int unsigned d);
		cfg_valid <= 1'b1;
		cfg_index <= CfgTargetTorque;
		cfg_data  <= t[TorqueWidth-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(CfgTargetTorque, t[TorqueWidth-1:0]);
		cfg_index <= CfgReportDelay;
		cfg_data  <= d[TorqueWidth-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(CfgReportDelay, d[TorqueWidth-1:0]);
		cfg_valid <= 1'b0;
	endtask

	// restart, ramp toward target, dwell around it, sometimes back off
	task automatic tightening_run(int unsigned t, int hold);
		int steps;
		push_sample(clamp16($urandom_range(0, t / 4)), 1'b1);
		steps = $urandom_range(1, 4);
		for (int i = 1; i <= steps; i++) begin
			push_sample(clamp16(t * i / (steps + 1) + $urandom_range(0, 3)), 1'b0);
		end
		for (int i = 0; i < hold; i++) begin
			push_sample(near_target(t), $urandom_range(0, 49) == 0);
		end
		if ($urandom_range(0, 2) == 0)
			push_sample(clamp16($urandom_range(0, t / 2)), 1'b0);
	endtask

	initial begin
		int start;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: target zero
		push_sample(16'd0, 1'b0);
		push_sample(16'hFFFF, 1'b1);
		push_sample(16'h5555, 1'b0);

		settle();
		write_limits(1000, 0);
		push_sample(16'd0, 1'b1);
		push_sample(16'd1000, 1'b0);
		push_sample(16'd999, 1'b0);
		push_sample(16'd750, 1'b0);
		push_sample(16'd751, 1'b0);
		push_sample(16'd1001, 1'b0);
		push_sample(16'd1001, 1'b0);
		push_sample(16'd1002, 1'b1);
		push_sample(16'd500, 1'b1);

		settle();
		write_limits(65535, 65535);
		push_sample(16'hFFFF, 1'b1);
		push_sample(16'd0, 1'b0);
		push_sample(16'hAAAA, 1'b0);

		settle();
		write_limits(1, 100);
		push_sample(16'd1, 1'b1);
		push_sample(16'd2, 1'b0);
		push_sample(16'd0, 1'b0);
		push_sample(16'd3, 1'b1);

		tgt[0] = 1000;  dly[0] = 500;
		tgt[1] = 65535; dly[1] = 0;
		tgt[2] = 0;     dly[2] = 0;
		tgt[3] = 1;     dly[3] = 100;
		tgt[4] = 40000; dly[4] = 65535;
		tgt[5] = 40000; dly[5] = 25500;
		tgt[6] = $urandom_range(2, 60000);  dly[6] = $urandom_range(0, 1500);
		tgt[7] = $urandom_range(2, 65535);  dly[7] = $urandom_range(0, 800);
		tgt[8] = $urandom_range(100, 5000); dly[8] = $urandom_range(0, 65535);

		for (int p = 0; p < 9; p++) begin
			settle();
			write_limits(tgt[p], dly[p]);
			calm = (p == 2 || p == 6);
			start = sent;
			// dwell counter is saturated from the previous phase
			if (p == 5)
				push_sample(clamp16(tgt[p] + 600), 1'b0);
			while (sent - start < 145) begin
				if ($urandom_range(0, 39) == 0)
					settle();
				if ($urandom_range(0, 4) == 0)
					push_sample(16'($urandom), $urandom_range(0, 7) == 0);
				else
					tightening_run(tgt[p], $urandom_range(1, 12));
			end
			if (p == 4) begin
				push_sample(clamp16(tgt[p] + 10), 1'b1);
				repeat (270) push_sample(clamp16(tgt[p] + $urandom_range(1, 500)), 1'b0);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.waiting() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
